[hw/rtl/sha1sh_pkg.sv]
// Shared types and constants for the SHA-1 stream hasher.
// Used by every module in hw/rtl; depends on nothing.
package sha1sh_pkg;

    // Input request: one absorb byte or a finish command.
    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } t_in;

    // Result request: the five digest words.
    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
    } t_out;

    // Five working or chaining words.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_work;

    // Commands from the sequencer to the compression unit.
    typedef struct packed {
        logic start;
        logic restore;
    } t_cmp_ctl;

    // Status from the compression unit to the sequencer.
    typedef struct packed {
        logic shift;
        logic done;
    } t_cmp_sts;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] K_ROUNDS_A = 32'h5a827999;
    localparam logic [31:0] K_ROUNDS_B = 32'h6ed9eba1;
    localparam logic [31:0] K_ROUNDS_C = 32'h8f1bbcdc;
    localparam logic [31:0] K_ROUNDS_D = 32'hca62c1d6;

    localparam t_work INIT_CHAIN = '{
        a: 32'h67452301,
        b: 32'hefcdab89,
        c: 32'h98badcfe,
        d: 32'h10325476,
        e: 32'hc3d2e1f0
    };

endpackage

[hw/rtl/sha1sh_round.sv]
// One SHA-1 round: the shared arithmetic unit reused for all 80 rounds.
// Depends on sha1sh_pkg for the working-word type and round constants.
module sha1sh_round (
    input  sha1sh_pkg::t_work i_work,
    input  logic [31:0]       i_w,
    input  logic [6:0]        i_rnd,
    output sha1sh_pkg::t_work o_work
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] t;

    always_comb begin
        if (i_rnd < 7'd20) begin
            f = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            k = sha1sh_pkg::K_ROUNDS_A;
        end else if (i_rnd < 7'd40) begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = sha1sh_pkg::K_ROUNDS_B;
        end else if (i_rnd < 7'd60) begin
            f = (i_work.b & i_work.c) | (i_work.b & i_work.d) | (i_work.c & i_work.d);
            k = sha1sh_pkg::K_ROUNDS_C;
        end else begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = sha1sh_pkg::K_ROUNDS_D;
        end
        t = {i_work.a[26:0], i_work.a[31:27]} + f + i_work.e + i_w + k;
        o_work.a = t;
        o_work.b = i_work.a;
        o_work.c = {i_work.b[1:0], i_work.b[31:2]};
        o_work.d = i_work.c;
        o_work.e = i_work.d;
    end

endmodule

[hw/rtl/sha1sh_compress.sv]
// Compression sequencer: working and chaining registers, round counter.
// Depends on sha1sh_pkg and instantiates sha1sh_round.
module sha1sh_compress (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha1sh_pkg::t_cmp_ctl i_ctl,
    input  logic [31:0]          i_w,
    output sha1sh_pkg::t_cmp_sts o_sts,
    output sha1sh_pkg::t_work    o_chain
);

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_ROUND = 2'd1;
    localparam logic [1:0] C_FOLD  = 2'd2;

    logic [1:0]        r_state;
    logic [6:0]        r_rnd;
    sha1sh_pkg::t_work r_work;
    sha1sh_pkg::t_work r_chain;
    sha1sh_pkg::t_work n_work;

    sha1sh_round u_round (
        .i_work (r_work),
        .i_w    (i_w),
        .i_rnd  (r_rnd),
        .o_work (n_work)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_rnd   <= '0;
            r_chain <= sha1sh_pkg::INIT_CHAIN;
        end else begin
            case (r_state)
                C_IDLE: begin
                    if (i_ctl.restore) begin
                        r_chain <= sha1sh_pkg::INIT_CHAIN;
                    end
                    if (i_ctl.start) begin
                        r_work  <= r_chain;
                        r_rnd   <= '0;
                        r_state <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    r_work <= n_work;
                    r_rnd  <= r_rnd + 7'd1;
                    if (r_rnd == 7'd79) begin
                        r_state <= C_FOLD;
                    end
                end
                C_FOLD: begin
                    r_chain.a <= r_chain.a + r_work.a;
                    r_chain.b <= r_chain.b + r_work.b;
                    r_chain.c <= r_chain.c + r_work.c;
                    r_chain.d <= r_chain.d + r_work.d;
                    r_chain.e <= r_chain.e + r_work.e;
                    r_state   <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign o_sts.shift = (r_state == C_ROUND);
    assign o_sts.done  = (r_state == C_FOLD);
    assign o_chain     = r_chain;

    // A new block is only started while the unit is free.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> r_state == C_IDLE)
        else $error("compression started while busy");

    // The fold follows directly on the last round, round 79.
    a_fold_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == C_FOLD |-> $past(r_rnd) == 7'd79)
        else $error("fold reached before the last round");

    // The round counter stays inside the 80 rounds.
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == C_ROUND |-> r_rnd < 7'd80)
        else $error("round counter out of range");

endmodule

[hw/rtl/sha1_stream_hasher_unit.sv]
// SHA-1 stream hasher top level: byte buffer and schedule, padding sequencer, result register.
// Depends on sha1sh_pkg and sha1sh_compress. An absorb request that completes a 64-byte
// block is followed by the 80 rounds on the shared round unit and a fold, and new requests
// stall until then. A finish writes the padding bytes one at a time, pauses once at the
// length field, compresses each block in the same way and then emits the digest.
// Reset (i_rst_n low at a clock edge) restores the SHA-1 initial chaining words.
module sha1_stream_hasher_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  sha1sh_pkg::t_in  i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output sha1sh_pkg::t_out o_out_data
);

    // Sequencer states. The padding states feed one byte per cycle into the block register
    // (but for one pause at the length field), so padding reuses the path of ordinary absorbs.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PADZ = 3'd1;
    localparam logic [2:0] S_PADL = 3'd2;
    localparam logic [2:0] S_HASH = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]           r_state;
    logic [5:0]           r_fill;
    logic [63:0]          r_len;
    logic                 r_fin;
    logic                 r_lenblk;
    logic [511:0]         r_blk;
    sha1sh_pkg::t_out     r_out;
    logic                 r_ovalid;

    logic                 in_acc;
    logic                 out_acc;
    logic [31:0]          w_head;
    logic [31:0]          w_mix;
    logic [31:0]          w_next;
    sha1sh_pkg::t_cmp_ctl cmp_ctl;
    sha1sh_pkg::t_cmp_sts cmp_sts;
    sha1sh_pkg::t_work    chain;

    // The 512-bit block register doubles as the message schedule. Bytes enter
    // at the low end, so after 64 bytes message byte 0 sits at the top and
    // word j of the block is the j-th 32-bit slice from the top. During the
    // rounds the register shifts one word per cycle: the top word is the
    // schedule word of the round, and the word fed in at the bottom is the
    // word that will be needed sixteen rounds later.
    assign w_head = r_blk[511:480];
    assign w_mix  = r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ w_head;
    assign w_next = {w_mix[30:0], w_mix[31]};

    // A finish must wait while an earlier digest is still pending, since it
    // would overwrite the result register. Absorbs may go ahead meanwhile.
    assign o_in_stall = (r_state != S_IDLE) ||
                        (r_ovalid && (i_in_data.action == sha1sh_pkg::ACT_FINISH));
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_ovalid && !i_out_stall;

    // A compression starts whenever the byte written this cycle is the last
    // one of the block.
    always_comb begin
        cmp_ctl.start = 1'b0;
        case (r_state)
            S_IDLE:  cmp_ctl.start = in_acc && (r_fill == 6'd63);
            S_PADZ:  cmp_ctl.start = (r_fill == 6'd63);
            S_PADL:  cmp_ctl.start = (r_fill == 6'd63);
            default: cmp_ctl.start = 1'b0;
        endcase
        cmp_ctl.restore = (r_state == S_EMIT);
    end

    sha1sh_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cmp_ctl),
        .i_w     (w_head),
        .o_sts   (cmp_sts),
        .o_chain (chain)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_len    <= '0;
            r_fin    <= 1'b0;
            r_lenblk <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_acc) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_fill <= r_fill + 6'd1;
                        if (i_in_data.action == sha1sh_pkg::ACT_FINISH) begin
                            // The pad mark is the first padding byte.
                            r_blk <= {r_blk[503:0], sha1sh_pkg::PAD_MARK};
                            r_fin <= 1'b1;
                            r_state <= (r_fill == 6'd63) ? S_HASH : S_PADZ;
                        end else begin
                            r_blk <= {r_blk[503:0], i_in_data.data_byte};
                            r_len <= r_len + 64'd8;
                            r_state <= (r_fill == 6'd63) ? S_HASH : S_IDLE;
                        end
                    end
                end
                S_PADZ: begin
                    // Zeros run to the end of the block when the pad mark
                    // landed past the length field, and then up to it.
                    if (r_fill == 6'd56) begin
                        r_lenblk <= 1'b1;
                        r_state  <= S_PADL;
                    end else begin
                        r_blk  <= {r_blk[503:0], 8'h00};
                        r_fill <= r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            r_state <= S_HASH;
                        end
                    end
                end
                S_PADL: begin
                    // The bit length goes out most significant byte first.
                    r_blk  <= {r_blk[503:0], r_len[63:56]};
                    r_len  <= {r_len[55:0], 8'h00};
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == 6'd63) begin
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (cmp_sts.shift) begin
                        r_blk <= {r_blk[479:0], w_next};
                    end
                    if (cmp_sts.done) begin
                        if (r_lenblk) begin
                            r_state <= S_EMIT;
                        end else if (r_fin) begin
                            r_state <= S_PADZ;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMIT: begin
                    // The chaining words are final here; the compression unit
                    // reloads the initial values at this same edge.
                    r_out.digest_word0 <= chain.a;
                    r_out.digest_word1 <= chain.b;
                    r_out.digest_word2 <= chain.c;
                    r_out.digest_word3 <= chain.d;
                    r_out.digest_word4 <= chain.e;
                    r_ovalid <= 1'b1;
                    r_fill   <= '0;
                    r_len    <= '0;
                    r_fin    <= 1'b0;
                    r_lenblk <= 1'b0;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // A digest only appears right after the emit state.
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_EMIT)
        else $error("result raised outside the emit state");

    // The length bytes occupy the last eight places of the block.
    a_len_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PADL |-> r_fill[5:3] == 3'b111)
        else $error("length bytes written outside the length field");

    // The emit state is never entered while an older digest is pending.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> !r_ovalid)
        else $error("pending digest would be overwritten");

    // The compression unit only reports completion while the sequencer waits.
    a_done_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmp_sts.done |-> r_state == S_HASH)
        else $error("compression finished outside the hash state");

endmodule
